// File: hdl/utf8v_pkg.sv
// Package for the UTF-8 validator: byte range constants, parser state type
// and the result saturation helper.
// No dependencies; used by utf8v_step and utf8_validate_and_count.
package utf8v_pkg;

	// Width of the internal character counter
	localparam int COUNT_BITS = 32;
	// Width of the char_count result field
	localparam int OUT_BITS   = 32;
	localparam int CMP_BITS   = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
	localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;

	// Lead byte classes
	localparam logic [7:0] ASCII_MAX  = 8'h7f;
	localparam logic [7:0] LEAD2_MIN  = 8'hc2;
	localparam logic [7:0] LEAD2_MAX  = 8'hdf;
	localparam logic [7:0] LEAD3_MIN  = 8'he0;
	localparam logic [7:0] LEAD3_MAX  = 8'hef;
	localparam logic [7:0] LEAD4_MIN  = 8'hf0;
	localparam logic [7:0] LEAD4_MAX  = 8'hf4;

	// Leads with a narrowed first continuation range
	localparam logic [7:0] LEAD_E0    = 8'he0;
	localparam logic [7:0] LEAD_ED    = 8'hed;
	localparam logic [7:0] LEAD_F0    = 8'hf0;
	localparam logic [7:0] LEAD_F4    = 8'hf4;

	// Continuation byte bounds
	localparam logic [7:0] TAIL_MIN    = 8'h80;
	localparam logic [7:0] TAIL_MAX    = 8'hbf;
	localparam logic [7:0] TAIL_E0_MIN = 8'ha0;
	localparam logic [7:0] TAIL_ED_MAX = 8'h9f;
	localparam logic [7:0] TAIL_F0_MIN = 8'h90;
	localparam logic [7:0] TAIL_F4_MAX = 8'h8f;

	// Number of continuation bytes a lead asks for
	localparam logic [1:0] TAILS_NONE = 2'd0;
	localparam logic [1:0] TAILS_ONE  = 2'd1;
	localparam logic [1:0] TAILS_TWO  = 2'd2;
	localparam logic [1:0] TAILS_THREE = 2'd3;

	// Parser state carried between bytes of one buffer
	typedef struct packed {
		logic [1:0]            tails;
		logic [7:0]            lead;
		logic                  first_tail;
		logic [COUNT_BITS-1:0] count;
		logic                  err;
	} parse_state_t;

	// Clamp the internal count to the result field width
	function automatic logic [OUT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
		logic [CMP_BITS-1:0] wide;
		wide = CMP_BITS'(c);
		if (wide > CMP_BITS'(OUT_MAX))
			return '1;
		return wide[OUT_BITS-1:0];
	endfunction

endpackage

// File: hdl/utf8v_step.sv
// Next-state logic for one byte of the UTF-8 parser.
// Purely combinational; depends on utf8v_pkg.
module utf8v_step import utf8v_pkg::*; (
	input  parse_state_t cur,
	input  logic [7:0]   byte_in,
	output parse_state_t nxt
);

	logic [COUNT_BITS-1:0] count_inc;
	logic [7:0]            lo;
	logic [7:0]            hi;
	logic                  tail_ok;

	// Saturating character count
	assign count_inc = (cur.count != '1) ? cur.count + COUNT_BITS'(1) : cur.count;

	// Allowed continuation range; first tail narrowed by some leads
	always_comb begin
		lo = TAIL_MIN;
		hi = TAIL_MAX;
		if (cur.first_tail) begin
			if (cur.lead == LEAD_E0)
				lo = TAIL_E0_MIN;
			else if (cur.lead == LEAD_ED)
				hi = TAIL_ED_MAX;
			else if (cur.lead == LEAD_F0)
				lo = TAIL_F0_MIN;
			else if (cur.lead == LEAD_F4)
				hi = TAIL_F4_MAX;
		end
	end

	assign tail_ok = (byte_in >= lo) && (byte_in <= hi);

	// Lead decode or continuation check
	always_comb begin
		nxt = cur;
		if (cur.tails == TAILS_NONE) begin
			priority if (byte_in <= ASCII_MAX) begin
				nxt.count = count_inc;
			end else if (byte_in >= LEAD2_MIN && byte_in <= LEAD2_MAX) begin
				nxt.tails      = TAILS_ONE;
				nxt.lead       = byte_in;
				nxt.first_tail = 1'b1;
			end else if (byte_in >= LEAD3_MIN && byte_in <= LEAD3_MAX) begin
				nxt.tails      = TAILS_TWO;
				nxt.lead       = byte_in;
				nxt.first_tail = 1'b1;
			end else if (byte_in >= LEAD4_MIN && byte_in <= LEAD4_MAX) begin
				nxt.tails      = TAILS_THREE;
				nxt.lead       = byte_in;
				nxt.first_tail = 1'b1;
			end else begin
				nxt.err = 1'b1;
			end
		end else if (!tail_ok) begin
			// bad tail drops the character in progress
			nxt.err        = 1'b1;
			nxt.tails      = TAILS_NONE;
			nxt.first_tail = 1'b0;
		end else begin
			nxt.first_tail = 1'b0;
			nxt.tails      = cur.tails - 2'd1;
			if (cur.tails == TAILS_ONE)
				nxt.count = count_inc;
		end
	end

endmodule

// File: hdl/utf8_validate_and_count.sv
// UTF-8 validator and character counter, top level.
// A result passes through two register stages: the input register, then the result register.
// Throughput: one byte per cycle, but a last byte waits while the result slot is full and not read;
// the parser state loop is one register with combinational next-state logic. A result appears only
// for the byte marked tlast; parser state then clears. Reset (arst_n low, asynchronous) empties
// both registers and clears the parser state. Depends on utf8v_pkg and utf8v_step.
module utf8_validate_and_count import utf8v_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// input byte stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
	input  logic                s_axis_tlast,  // last_byte
	// result stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_BITS-1:0] m_axis_tdata,  // [31:0] char_count
	output logic                m_axis_tuser   // invalid
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         out_valid_q;
	logic [OUT_BITS-1:0] out_count_q;
	logic         out_invalid_q;
	logic         adv;
	logic         bad;

	// Stage 1 moves on unless it holds a last byte while the result slot is full and not being read
	assign adv = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	utf8v_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.nxt     (state_nxt)
	);

	assign bad = state_nxt.err || (state_nxt.tails != TAILS_NONE);

	// Parser state; cleared after each buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= last_s1 ? '0 : state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_count_q   <= bad ? '0 : sat_count(state_nxt.count);
			out_invalid_q <= bad;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_count_q;
	assign m_axis_tuser  = out_invalid_q;

	// Checks
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && last_s1))
		else $error("result appeared without a last byte");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_invalid_q) |-> (out_count_q == '0))
		else $error("invalid result carries a nonzero count");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (state_q == '0))
		else $error("parser state not cleared after buffer end");

	a_first_tail: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.first_tail |-> (state_q.tails != TAILS_NONE))
		else $error("first tail pending with no tails expected");

endmodule

// File: verif/tb_top.sv
// Testbench for utf8_validate_and_count: directed and random byte buffers are
// streamed in and each result is checked against a behavioral UTF-8 predictor.
// Depends on utf8v_pkg and the utf8_validate_and_count RTL.
`timescale 1ns / 100ps

module tb_top;
	import utf8v_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;

	// Kinds of damage applied to a well-formed buffer
	typedef enum int {
		FAULT_NONE,
		FAULT_SWAP,
		FAULT_CUT,
		FAULT_BAD_LEAD
	} fault_t;

	typedef struct {
		logic [OUT_BITS-1:0] char_count;
		logic                invalid;
	} utf8_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;
	logic                s_axis_tlast = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_BITS-1:0] m_axis_tdata;
	logic                m_axis_tuser;

	// Predictor state for the buffer in progress
	logic [1:0]            tails_left = TAILS_NONE;
	logic [7:0]            lead_byte = '0;
	logic                  on_first_tail = 1'b0;
	logic [COUNT_BITS-1:0] chars_done = '0;
	logic                  saw_error = 1'b0;

	utf8_result_t pending_results[$];
	logic [7:0]   frame_q[$];

	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	bit send_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	int rx_run = 0;
	bit rx_open = 1'b1;

	utf8_validate_and_count DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver back-pressure: alternating runs of ready and stall
	always @(negedge clk) begin
		if (rx_run == 0) begin
			rx_open = ~rx_open;
			rx_run = rx_open ? $urandom_range(1, 20) : $urandom_range(1, 8);
		end
		rx_run = rx_run - 1;
		m_axis_tready <= rx_open || !rx_stalls;
	end

	// Bump the character count, holding at all ones
	task automatic count_one_char();
		if (chars_done != '1)
			chars_done = chars_done + 1'b1;
	endtask

	// Advance the predictor by one accepted byte; queue a result on tlast
	task automatic track_byte(input logic [7:0] b, input logic is_last);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [63:0] wide;
		utf8_result_t res;
		if (tails_left == TAILS_NONE) begin
			if (b <= ASCII_MAX) begin
				count_one_char();
			end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
				tails_left = TAILS_ONE;
			end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
				tails_left = TAILS_TWO;
			end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
				tails_left = TAILS_THREE;
			end else begin
				saw_error = 1'b1;
			end
			if (tails_left != TAILS_NONE) begin
				lead_byte = b;
				on_first_tail = 1'b1;
			end
		end else begin
			lo = TAIL_MIN;
			hi = TAIL_MAX;
			// first continuation has a narrowed window after some leads
			if (on_first_tail) begin
				case (lead_byte)
					LEAD_E0: lo = TAIL_E0_MIN;
					LEAD_ED: hi = TAIL_ED_MAX;
					LEAD_F0: lo = TAIL_F0_MIN;
					LEAD_F4: hi = TAIL_F4_MAX;
					default: ;
				endcase
			end
			if (b < lo || b > hi) begin
				saw_error = 1'b1;
				tails_left = TAILS_NONE;
				on_first_tail = 1'b0;
			end else begin
				on_first_tail = 1'b0;
				tails_left = tails_left - 1'b1;
				if (tails_left == TAILS_NONE)
					count_one_char();
			end
		end
		if (is_last) begin
			wide = 64'(chars_done);
			res.invalid = saw_error || (tails_left != TAILS_NONE);
			if (res.invalid)
				res.char_count = '0;
			else if (wide > OUT_MAX)
				res.char_count = '1;
			else
				res.char_count = wide[OUT_BITS-1:0];
			pending_results.push_back(res);
			tails_left = TAILS_NONE;
			lead_byte = '0;
			on_first_tail = 1'b0;
			chars_done = '0;
			saw_error = 1'b0;
		end
	endtask

	// Drive one byte in bursts, with random gaps when send_gaps is set; returns right after acceptance
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = send_gaps ? $urandom_range(0, 5) : 0;
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
		end
		burst_left = burst_left - 1;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		track_byte(b, is_last);
	endtask

	// Send frame_q as one buffer, tlast on the final byte
	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic sender_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// Append one well-formed character with random content to frame_q
	task automatic add_char();
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		int n_tails;
		case ($urandom_range(0, 4))
			0: begin
				lead = 8'($urandom_range(0, ASCII_MAX));
				n_tails = 0;
			end
			1: begin
				lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
				n_tails = 1;
			end
			2: begin
				lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
				n_tails = 2;
			end
			3: begin
				lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
				n_tails = 3;
			end
			default: begin
				// leads with a narrowed first continuation
				case ($urandom_range(0, 3))
					0: lead = LEAD_E0;
					1: lead = LEAD_ED;
					2: lead = LEAD_F0;
					default: lead = LEAD_F4;
				endcase
				n_tails = (lead >= LEAD4_MIN) ? 3 : 2;
			end
		endcase
		frame_q.push_back(lead);
		lo = TAIL_MIN;
		hi = TAIL_MAX;
		case (lead)
			LEAD_E0: lo = TAIL_E0_MIN;
			LEAD_ED: hi = TAIL_ED_MAX;
			LEAD_F0: lo = TAIL_F0_MIN;
			LEAD_F4: hi = TAIL_F4_MAX;
			default: ;
		endcase
		for (int t = 0; t < n_tails; t++) begin
			// lean on the window edges now and then
			case ($urandom_range(0, 3))
				0: frame_q.push_back(lo);
				1: frame_q.push_back(hi);
				default: frame_q.push_back(8'($urandom_range(lo, hi)));
			endcase
			lo = TAIL_MIN;
			hi = TAIL_MAX;
		end
	endtask

	// Build a random buffer of characters, damaged now and then
	task automatic build_frame(input int max_chars, input int fault_pct);
		int n_chars;
		int pos;
		fault_t fault;
		frame_q.delete();
		n_chars = $urandom_range(1, max_chars);
		repeat (n_chars) add_char();
		fault = FAULT_NONE;
		if ($urandom_range(0, 99) < fault_pct)
			fault = fault_t'($urandom_range(FAULT_SWAP, FAULT_BAD_LEAD));
		pos = $urandom_range(0, frame_q.size() - 1);
		case (fault)
			FAULT_SWAP: frame_q[pos] = 8'($urandom_range(0, 255));
			FAULT_CUT: frame_q.pop_back();
			FAULT_BAD_LEAD: begin
				if ($urandom_range(0, 1))
					frame_q.insert(pos, 8'($urandom_range(TAIL_MIN, LEAD2_MIN - 1)));
				else
					frame_q.insert(pos, 8'($urandom_range(LEAD4_MAX + 1, 8'hff)));
			end
			default: ;
		endcase
		if (frame_q.size() == 0)
			frame_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Directed buffers: lead classes, narrowed windows, bad leads, truncation
	task automatic test_directed();
		frame_q = '{8'h00};
		send_frame();
		frame_q = '{8'h7f, 8'hc2, 8'h80, 8'hdf, 8'hbf};
		send_frame();
		frame_q = '{8'he0, 8'ha0, 8'hbf, 8'hed, 8'h9f, 8'h80};
		send_frame();
		frame_q = '{8'hf0, 8'h90, 8'h80, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_frame();
		// first continuation outside each narrowed window
		frame_q = '{8'he0, 8'h9f};
		send_frame();
		frame_q = '{8'hed, 8'ha0};
		send_frame();
		frame_q = '{8'hf0, 8'h8f};
		send_frame();
		frame_q = '{8'hf4, 8'h90};
		send_frame();
		// bad leads at both ends of the 80..c1 range and the low end of f5..ff
		frame_q = '{8'h80};
		send_frame();
		frame_q = '{8'hc1};
		send_frame();
		frame_q = '{8'hf5};
		send_frame();
		// error stays sticky while later bytes parse fine
		frame_q = '{8'hff, 8'h41};
		send_frame();
		// character cut off by the end of the buffer
		frame_q = '{8'he2, 8'h82};
		send_frame();
		// bad later continuation
		frame_q = '{8'he2, 8'h82, 8'hc0};
		send_frame();
	endtask

	// Mostly well-formed buffers with random content and some damage
	task automatic test_random_frames(input int n_bytes);
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			build_frame(8, 25);
			send_frame();
			sent = sent + frame_q.size();
		end
	endtask

	// Unstructured bytes with random tlast
	task automatic test_random_noise(input int n_bytes);
		logic is_last;
		for (int i = 0; i < n_bytes; i++) begin
			is_last = ($urandom_range(0, 5) == 0) || (i == n_bytes - 1);
			send_byte(8'($urandom_range(0, 255)), is_last);
		end
	endtask

	// Full-rate stretch: no sender gaps, receiver always ready
	task automatic test_full_rate(input int n_bytes);
		send_gaps = 1'b0;
		rx_stalls = 1'b0;
		test_random_frames(n_bytes);
		send_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	// Result checker: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		utf8_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: char_count=%0d invalid=%0b",
					m_axis_tdata, m_axis_tuser);
				errors = errors + 1;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata !== want.char_count) begin
					$error("char_count mismatch: expected %0d, got %0d",
						want.char_count, m_axis_tdata);
					errors = errors + 1;
				end
				if (m_axis_tuser !== want.invalid) begin
					$error("invalid mismatch: expected %0b, got %0b",
						want.invalid, m_axis_tuser);
					errors = errors + 1;
				end
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_frames(220);
		test_random_noise(100);
		test_full_rate(80);

		sender_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: utf8_validate_and_count.f
hdl/utf8v_pkg.sv
hdl/utf8v_step.sv
hdl/utf8_validate_and_count.sv
verif/tb_top.sv
